// File: rtl/kmc_linear_event_selector_macros.svh
// Assertion macros shared by the checker of the linear event selector.
`ifndef KMC_LINEAR_EVENT_SELECTOR_MACROS_SVH
`define KMC_LINEAR_EVENT_SELECTOR_MACROS_SVH

// Checked at every rising edge outside reset.
`define KLES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define KLES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: rtl/kmcles_pkg.sv
// Shared types, constants and state encodings of the linear event selector.
`timescale 1ns / 1ps
package kmcles_pkg;

  localparam int unsigned MAX_EVENTS_DEF = 1024;
  localparam int unsigned RATE_BITS_DEF  = 32;
  localparam int unsigned TOTAL_W        = 42;
  localparam int unsigned TSIZE_W        = 11;
  localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1024;
  localparam logic [31:0] LN2_Q32        = 32'd2977044472;

  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_SELECT = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [9:0]  entry_index;
    logic [31:0] rate_value;
    logic [31:0] draw_select;
    logic [31:0] draw_time;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         chosen_event;
    logic [0:0]         no_event;
    logic [63:0]        time_step;
    logic [10:0]        active_entries;
    logic [TOTAL_W-1:0] rate_total;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [31:0]        draw;
    logic [TOTAL_W-1:0] total;
  } dt_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } dt_rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_UPD_WR,
    ST_THR_MUL,
    ST_THR_ADD,
    ST_SCAN,
    ST_DT,
    ST_RESP
  } state_e;

  typedef enum logic [2:0] {
    DT_IDLE,
    DT_NORM,
    DT_SQR,
    DT_LNMUL,
    DT_LNADD,
    DT_DIV,
    DT_DONE
  } dt_state_e;

endpackage

// File: rtl/kmcles_dt.sv
// Waiting time unit: -ln(draw) by iterated squaring, then division by the total.
`timescale 1ns / 1ps
module kmcles_dt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kmcles_pkg::dt_req_t req_i,
  output kmcles_pkg::dt_rsp_t rsp_o
);
  import kmcles_pkg::*;

  dt_state_e          st_q, st_d;
  logic [31:0]        m_q, m_d;
  logic [4:0]         s_q, s_d;
  logic [31:0]        f_q, f_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [5:0]         dcnt_q, dcnt_d;
  logic [TOTAL_W-1:0] tot_q, tot_d;
  logic [37:0]        lnhi_q, lnhi_d;
  logic [63:0]        lnlo_q, lnlo_d;
  logic [53:0]        dvd_q, dvd_d;
  logic [TOTAL_W-1:0] rem_q, rem_d;
  logic [63:0]        val_q, val_d;

  logic [63:0]        sq;
  logic [32:0]        sq_sh;
  logic [37:0]        l2;
  logic [37:0]        ln;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W:0]   diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DT_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    s_q    <= s_d;
    f_q    <= f_d;
    cnt_q  <= cnt_d;
    dcnt_q <= dcnt_d;
    tot_q  <= tot_d;
    lnhi_q <= lnhi_d;
    lnlo_q <= lnlo_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    val_q  <= val_d;
  end

  always_comb begin
    st_d   = st_q;
    m_d    = m_q;
    s_d    = s_q;
    f_d    = f_q;
    cnt_d  = cnt_q;
    dcnt_d = dcnt_q;
    tot_d  = tot_q;
    lnhi_d = lnhi_q;
    lnlo_d = lnlo_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    val_d  = val_q;
    sq     = 64'(m_q) * 64'(m_q);
    sq_sh  = sq[63:31];
    l2     = {6'(s_q) + 6'd1, 32'd0} - {6'd0, f_q};
    ln     = lnhi_q + 38'(lnlo_q[63:32]);
    trial  = {rem_q, dvd_q[53]};
    diff   = trial - {1'b0, tot_q};
    case (st_q)
      DT_IDLE: begin
        if (req_i.start) begin
          tot_d = req_i.total;
          m_d   = req_i.draw;
          s_d   = '0;
          f_d   = '0;
          cnt_d = 5'd31;
          if (req_i.draw == '0 || req_i.total == '0) begin
            val_d = '1;
            st_d  = DT_DONE;
          end else begin
            st_d = DT_NORM;
          end
        end
      end
      DT_NORM: begin
        if (m_q[31]) begin
          st_d = DT_SQR;
        end else begin
          m_d = {m_q[30:0], 1'b0};
          s_d = s_q + 5'd1;
        end
      end
      DT_SQR: begin
        if (sq_sh[32]) begin
          m_d        = sq_sh[32:1];
          f_d[cnt_q] = 1'b1;
        end else begin
          m_d = sq_sh[31:0];
        end
        if (cnt_q == '0) begin
          st_d = DT_LNMUL;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      DT_LNMUL: begin
        lnhi_d = 38'(l2[37:32]) * 38'(LN2_Q32);
        lnlo_d = 64'(l2[31:0]) * 64'(LN2_Q32);
        st_d   = DT_LNADD;
      end
      DT_LNADD: begin
        dvd_d  = {ln, 16'd0};
        rem_d  = '0;
        dcnt_d = 6'd53;
        st_d   = DT_DIV;
      end
      DT_DIV: begin
        if (!diff[TOTAL_W]) begin
          rem_d = diff[TOTAL_W-1:0];
          dvd_d = {dvd_q[52:0], 1'b1};
        end else begin
          rem_d = trial[TOTAL_W-1:0];
          dvd_d = {dvd_q[52:0], 1'b0};
        end
        if (dcnt_q == '0) begin
          val_d = 64'(dvd_d);
          st_d  = DT_DONE;
        end else begin
          dcnt_d = dcnt_q - 6'd1;
        end
      end
      DT_DONE: begin
        st_d = DT_IDLE;
      end
      default: begin
        st_d = DT_IDLE;
      end
    endcase
  end

  assign rsp_o.done  = (st_q == DT_DONE);
  assign rsp_o.value = val_q;

endmodule

// File: rtl/kmc_linear_event_selector.sv
// Top level of the linear-search event selector with its rate memory and control.
`timescale 1ns / 1ps
// The block holds MAX_EVENTS rates in a single-port-write, registered-read memory
// together with their exact total and a count of positive entries. After reset a
// clearing pass writes zero to every entry, one per cycle, so no item is taken
// until the pass ends; configuration writes are taken throughout. An update reads
// the entry in ST_IDLE and writes it back in ST_UPD_WR. A select with no active
// entry goes from ST_IDLE straight to ST_RESP; otherwise it passes through
// ST_THR_MUL, ST_THR_ADD, ST_SCAN, ST_DT and ST_RESP. The walk in ST_SCAN stops at
// the first entry whose prefix sum passes the threshold, or at the last entry of
// the scan length. A zero draw_time or a zero total skips the logarithm and the
// division. The walk reads one entry per cycle from the memory port, the logarithm
// squares once per cycle and the division produces one quotient bit per cycle. One
// item is processed at a time; a finished result waits in the output register
// while the next item is taken.
module kmc_linear_event_selector #(
  parameter int unsigned MAX_EVENTS = kmcles_pkg::MAX_EVENTS_DEF,
  parameter int unsigned RATE_BITS  = kmcles_pkg::RATE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  kmcles_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output kmcles_pkg::out_item_t out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import kmcles_pkg::*;

  localparam int unsigned AW = $clog2(MAX_EVENTS);
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned PW = RATE_BITS + AW;
  localparam int unsigned XW = (PW > TOTAL_W) ? PW : TOTAL_W;
  localparam int unsigned SW = ((AW + 1) > TSIZE_W) ? (AW + 1) : TSIZE_W;
  localparam int unsigned IW = ((AW + 1) > 10) ? (AW + 1) : 10;
  localparam logic [31:0] RMASK =
    (RATE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << RATE_BITS) - 64'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_EVENTS - 1);

  logic [RATE_BITS-1:0] mem_q [MAX_EVENTS];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [RATE_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [RATE_BITS-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  state_e               state_q, state_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [CW-1:0]        count_q, count_d;
  logic [TSIZE_W-1:0]   tsize_q;
  logic                 out_valid_q, out_valid_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic                 issue_q, issue_d;
  logic                 rd_vld_q, rd_vld_d;

  in_item_t             item_q, item_d;
  out_item_t            res_q, res_d;
  out_item_t            out_q, out_d;
  logic [63:0]          plo_q, plo_d;
  logic [TOTAL_W-1:0]   phi_q, phi_d;
  logic [TOTAL_W-1:0]   thr_q, thr_d;
  logic [PW-1:0]        partial_q, partial_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [AW-1:0]        chosen_q, chosen_d;

  logic [SW-1:0]        ts_ext;
  logic [SW-1:0]        scan_len;
  logic [AW-1:0]        scan_last;
  logic                 idx_ok;
  logic [RATE_BITS-1:0] new_rate;
  logic [PW-1:0]        psum;
  logic                 hit;
  logic                 cfg_we;
  dt_req_t              dt_req;
  dt_rsp_t              dt_rsp;

  assign ts_ext    = SW'(tsize_q);
  assign scan_len  = (ts_ext == '0) ? SW'(1) :
                     ((ts_ext > SW'(MAX_EVENTS)) ? SW'(MAX_EVENTS) : ts_ext);
  assign scan_last = AW'(scan_len - SW'(1));
  assign idx_ok    = IW'(in_data_i.entry_index) < IW'(MAX_EVENTS);
  assign new_rate  = RATE_BITS'(item_q.rate_value & RMASK);
  assign psum      = partial_q + PW'(mem_rdata_q);
  assign hit       = (XW'(psum) > XW'(thr_q)) || (rd_idx_q == scan_last);

  kmcles_dt u_dt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dt_req),
    .rsp_o  (dt_rsp)
  );

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_SIZE) ? 32'(tsize_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= TSIZE_RESET;
    end else if (cfg_we && paddr[2] == REG_TABLE_SIZE) begin
      tsize_q <= pwdata[TSIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      total_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      addr_q      <= addr_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    res_q     <= res_d;
    out_q     <= out_d;
    plo_q     <= plo_d;
    phi_q     <= phi_d;
    thr_q     <= thr_d;
    partial_q <= partial_d;
    rd_idx_q  <= rd_idx_d;
    chosen_q  <= chosen_d;
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    addr_d      = addr_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    thr_d       = thr_q;
    partial_d   = partial_q;
    rd_idx_d    = rd_idx_q;
    chosen_d    = chosen_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '0;
    mem_raddr   = AW'(in_data_i.entry_index);
    in_ready_o  = 1'b0;
    dt_req.start = 1'b0;
    dt_req.draw  = item_q.draw_time;
    dt_req.total = total_q;
    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.opcode == OP_UPDATE) begin
            if (idx_ok) begin
              state_d = ST_UPD_WR;
            end
          end else if (count_q == '0) begin
            total_d = '0;
            res_d   = '0;
            res_d.no_event = 1'b1;
            state_d = ST_RESP;
          end else begin
            state_d = ST_THR_MUL;
          end
        end
      end
      ST_UPD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(item_q.entry_index);
        mem_wdata = new_rate;
        count_d   = count_q - CW'(mem_rdata_q != '0) + CW'(new_rate != '0);
        total_d   = total_q - TOTAL_W'(mem_rdata_q) + TOTAL_W'(new_rate);
        state_d   = ST_IDLE;
      end
      ST_THR_MUL: begin
        plo_d   = 64'(total_q[31:0]) * 64'(item_q.draw_select);
        phi_d   = TOTAL_W'(total_q[TOTAL_W-1:32]) * TOTAL_W'(item_q.draw_select);
        state_d = ST_THR_ADD;
      end
      ST_THR_ADD: begin
        thr_d     = phi_q + TOTAL_W'(plo_q[63:32]);
        addr_d    = '0;
        issue_d   = 1'b1;
        partial_d = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        mem_raddr = addr_q;
        if (issue_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q;
          if (addr_q == scan_last) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q + AW'(1);
          end
        end
        if (rd_vld_q) begin
          partial_d = psum;
          if (hit) begin
            chosen_d     = rd_idx_q;
            issue_d      = 1'b0;
            rd_vld_d     = 1'b0;
            dt_req.start = 1'b1;
            state_d      = ST_DT;
          end
        end
      end
      ST_DT: begin
        if (dt_rsp.done) begin
          res_d.chosen_event   = 10'(chosen_q);
          res_d.no_event       = 1'b0;
          res_d.time_step      = dt_rsp.value;
          res_d.active_entries = 11'(count_q);
          res_d.rate_total     = total_q;
          state_d              = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/kmcles_checker.sv
// Port-level checker of the linear event selector and its bind statement.
`timescale 1ns / 1ps
`include "kmc_linear_event_selector_macros.svh"
module kmcles_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input kmcles_pkg::out_item_t out_data_o,
  input logic                  pready
);
  import kmcles_pkg::*;

  logic none_cleared;
  logic none_result;
  logic event_result;

  assign none_cleared = (out_data_o.time_step == '0) && (out_data_o.rate_total == '0) &&
                        (out_data_o.chosen_event == '0) &&
                        (out_data_o.active_entries == '0);
  assign none_result  = out_valid_o && (out_data_o.no_event == 1'b1);
  assign event_result = out_valid_o && (out_data_o.no_event == 1'b0);

  `KLES_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
  `KLES_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result transfer lost")
  `KLES_ASSERT(a_no_event_zero, none_result |-> none_cleared, "no-event result not cleared")
  `KLES_ASSERT(a_event_active, event_result |-> out_data_o.active_entries != '0, "no active entry")

endmodule

bind kmc_linear_event_selector kmcles_checker u_checker (.*);
